// ===== design/nearest_target_select_core_macros.svh =====
// ----------------------------------------------------------------------------
// nearest_target_select_core_macros.svh
// Assertion macros for the nearest target select core. In synthesis the
// macros expand to nothing.
// ----------------------------------------------------------------------------
`ifndef NEAREST_TARGET_SELECT_CORE_MACROS_SVH
`define NEAREST_TARGET_SELECT_CORE_MACROS_SVH

`ifndef SYNTHESIS
// Same-cycle implication, checked at every rising clock edge out of reset.
`define NTS_ASSERT_IMP(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("nearest_target_select_core: check failed");
// Next-cycle implication.
`define NTS_ASSERT_NXT(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("nearest_target_select_core: check failed");
`else
`define NTS_ASSERT_IMP(name, ante, cons)
`define NTS_ASSERT_NXT(name, ante, cons)
`endif

`endif

// ===== design/ntsel_pkg.sv =====
// ----------------------------------------------------------------------------
// ntsel_pkg
// Types and constants shared by the nearest target select core.
// ----------------------------------------------------------------------------
package ntsel_pkg;

  // Field widths.
  localparam int COORD_BITS = 24;
  localparam int DIFF_W     = COORD_BITS + 1;
  localparam int SQ_W       = 2 * COORD_BITS;
  localparam int DIST_W     = 50;
  localparam int RAD_W      = 23;
  localparam int TEAM_W     = 8;
  localparam int IDX_W      = 20;
  localparam int GEN_W      = 12;
  localparam int SLOT_W     = 10;
  localparam int SLOT_FIELD_MAX = (1 << SLOT_W) - 1;

  // Stream and configuration port widths.
  localparam int IN_TDATA_W  = 112;
  localparam int OUT_TDATA_W = 96;
  localparam int CFG_ADDR_W  = 3;
  localparam int CFG_DATA_W  = 24;

  // Depth of the queue between front and back.
  localparam int QUEUE_DEPTH = 4;
  localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);

  // Configuration register indexes.
  typedef enum logic [CFG_ADDR_W-1:0] {
    REG_SELF_X     = 3'd0,
    REG_SELF_Y     = 3'd1,
    REG_SELF_Z     = 3'd2,
    REG_RADIUS     = 3'd3,
    REG_SELF_TEAM  = 3'd4,
    REG_SELF_INDEX = 3'd5,
    REG_SELF_GEN   = 3'd6
  } cfg_reg_t;

  // Searcher settings as seen by the datapath.
  typedef struct packed {
    logic [COORD_BITS-1:0] self_x;
    logic [COORD_BITS-1:0] self_y;
    logic [COORD_BITS-1:0] self_z;
    logic [RAD_W-1:0]      acquire_radius;
    logic [TEAM_W-1:0]     self_team;
    logic [IDX_W-1:0]      self_index;
    logic [GEN_W-1:0]      self_generation;
  } cfg_t;

  // One classified candidate on its way from front to back.
  typedef struct packed {
    logic [DIST_W-1:0] dist_sq;
    logic [IDX_W-1:0]  index;
    logic [GEN_W-1:0]  gen;
    logic [SLOT_W-1:0] slot;
    logic              hit;
    logic              last;
  } q_entry_t;

  // Queue fill status.
  typedef struct packed {
    logic full;
    logic empty;
  } q_status_t;

endpackage

// ===== design/ntsel_front.sv =====
// ----------------------------------------------------------------------------
// ntsel_front
// Accepts candidate beats, classifies eligibility, numbers list slots and
// forms the squared distance over three pipeline stages.
// ----------------------------------------------------------------------------
module ntsel_front #(
  parameter int SLOT_TOP = 1023
) (
  input  logic                                clk,
  input  logic                                rst,
  input  ntsel_pkg::cfg_t                     cfg,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic [ntsel_pkg::COORD_BITS-1:0]    in_x,
  input  logic [ntsel_pkg::COORD_BITS-1:0]    in_y,
  input  logic [ntsel_pkg::COORD_BITS-1:0]    in_z,
  input  logic [ntsel_pkg::TEAM_W-1:0]        in_team,
  input  logic [ntsel_pkg::IDX_W-1:0]         in_index,
  input  logic [ntsel_pkg::GEN_W-1:0]         in_gen,
  input  logic                                in_usable,
  input  logic                                in_last,
  input  ntsel_pkg::q_status_t                q_status,
  output logic                                q_push,
  output ntsel_pkg::q_entry_t                 q_wdata
);
  import ntsel_pkg::*;

  localparam int SLOT_CW = $clog2(SLOT_TOP + 1);

  logic                      advance;
  logic                      accept;
  logic [SLOT_CW-1:0]        slot_cnt;
  logic                      elig;

  logic                      s1_valid;
  logic signed [DIFF_W-1:0]  s1_dx, s1_dy, s1_dz;
  logic                      s1_hit, s1_last;
  logic [IDX_W-1:0]          s1_index;
  logic [GEN_W-1:0]          s1_gen;
  logic [SLOT_W-1:0]         s1_slot;

  logic signed [2*DIFF_W-1:0] prod_x, prod_y, prod_z;

  logic                      s2_valid;
  logic [SQ_W-1:0]           s2_sqx, s2_sqy, s2_sqz;
  logic                      s2_hit, s2_last;
  logic [IDX_W-1:0]          s2_index;
  logic [GEN_W-1:0]          s2_gen;
  logic [SLOT_W-1:0]         s2_slot;

  logic                      s3_valid;
  logic [DIST_W-1:0]         s3_dist;
  logic                      s3_hit, s3_last;
  logic [IDX_W-1:0]          s3_index;
  logic [GEN_W-1:0]          s3_gen;
  logic [SLOT_W-1:0]         s3_slot;

  // The whole pipeline moves unless its last stage waits on a full queue.
  assign advance  = !s3_valid || !q_status.full;
  assign in_ready = advance;
  assign accept   = in_valid && advance;
  assign q_push   = s3_valid && !q_status.full;

  // A candidate counts if usable, not the searcher and on another team.
  assign elig = in_usable
             && !(in_index == cfg.self_index && in_gen == cfg.self_generation)
             && (in_team != cfg.self_team);

  // Slot numbering saturates at the top slot and restarts after a last beat.
  always_ff @(posedge clk) begin
    if (rst) begin
      slot_cnt <= '0;
    end else if (accept) begin
      if (in_last) begin
        slot_cnt <= '0;
      end else if (slot_cnt < SLOT_CW'(SLOT_TOP)) begin
        slot_cnt <= slot_cnt + 1'b1;
      end
    end
  end

  // Stage valid bits.
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      s2_valid <= 1'b0;
      s3_valid <= 1'b0;
    end else if (advance) begin
      s1_valid <= accept;
      s2_valid <= s1_valid;
      s3_valid <= s2_valid;
    end
  end

  // Stage 1: per-axis differences, sign extended by one bit.
  always_ff @(posedge clk) begin
    if (advance) begin
      s1_dx    <= {in_x[COORD_BITS-1], in_x} - {cfg.self_x[COORD_BITS-1], cfg.self_x};
      s1_dy    <= {in_y[COORD_BITS-1], in_y} - {cfg.self_y[COORD_BITS-1], cfg.self_y};
      s1_dz    <= {in_z[COORD_BITS-1], in_z} - {cfg.self_z[COORD_BITS-1], cfg.self_z};
      s1_hit   <= elig;
      s1_last  <= in_last;
      s1_index <= in_index;
      s1_gen   <= in_gen;
      s1_slot  <= SLOT_W'(slot_cnt);
    end
  end

  // Stage 2: one signed square per axis.
  always_comb begin
    prod_x = s1_dx * s1_dx;
    prod_y = s1_dy * s1_dy;
    prod_z = s1_dz * s1_dz;
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      s2_sqx   <= prod_x[SQ_W-1:0];
      s2_sqy   <= prod_y[SQ_W-1:0];
      s2_sqz   <= prod_z[SQ_W-1:0];
      s2_hit   <= s1_hit;
      s2_last  <= s1_last;
      s2_index <= s1_index;
      s2_gen   <= s1_gen;
      s2_slot  <= s1_slot;
    end
  end

  // Stage 3: sum of squares; it cannot overflow at this coordinate width.
  always_ff @(posedge clk) begin
    if (advance) begin
      s3_dist  <= DIST_W'(s2_sqx) + DIST_W'(s2_sqy) + DIST_W'(s2_sqz);
      s3_hit   <= s2_hit;
      s3_last  <= s2_last;
      s3_index <= s2_index;
      s3_gen   <= s2_gen;
      s3_slot  <= s2_slot;
    end
  end

  // Queue entry.
  always_comb begin
    q_wdata.dist_sq = s3_dist;
    q_wdata.index   = s3_index;
    q_wdata.gen     = s3_gen;
    q_wdata.slot    = s3_slot;
    q_wdata.hit     = s3_hit;
    q_wdata.last    = s3_last;
  end

endmodule

// ===== design/ntsel_fifo.sv =====
// ----------------------------------------------------------------------------
// ntsel_fifo
// Short queue of classified candidates between front and back.
// ----------------------------------------------------------------------------
module ntsel_fifo (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   push,
  input  ntsel_pkg::q_entry_t    wdata,
  input  logic                   pop,
  output ntsel_pkg::q_entry_t    rdata,
  output ntsel_pkg::q_status_t   status
);
  import ntsel_pkg::*;

  q_entry_t              mem [QUEUE_DEPTH];
  logic [QUEUE_AW-1:0]   wr_ptr;
  logic [QUEUE_AW-1:0]   rd_ptr;
  logic [QUEUE_AW:0]     count;

  // Entry storage.
  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= wdata;
    end
  end

  assign rdata = mem[rd_ptr];

  // Pointers wrap naturally since the depth is a power of two.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  assign status.full  = (count == (QUEUE_AW + 1)'(QUEUE_DEPTH));
  assign status.empty = (count == '0);

endmodule

// ===== design/ntsel_back.sv =====
// ----------------------------------------------------------------------------
// ntsel_back
// Checks range, keeps the running nearest candidate and holds the result
// beat of each list until it is taken.
// ----------------------------------------------------------------------------
module ntsel_back (
  input  logic                            clk,
  input  logic                            rst,
  input  logic [ntsel_pkg::RAD_W-1:0]     acquire_radius,
  input  ntsel_pkg::q_status_t            q_status,
  input  ntsel_pkg::q_entry_t             q_rdata,
  output logic                            q_pop,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic                            out_found,
  output logic [ntsel_pkg::IDX_W-1:0]     out_index,
  output logic [ntsel_pkg::GEN_W-1:0]     out_gen,
  output logic [ntsel_pkg::SLOT_W-1:0]    out_slot,
  output logic [ntsel_pkg::DIST_W-1:0]    out_dist
);
  import ntsel_pkg::*;

  logic [2*RAD_W-1:0]  r2_full;
  logic [DIST_W-1:0]   r2;

  logic                have_best;
  logic [DIST_W-1:0]   best_dist;
  logic [IDX_W-1:0]    best_index;
  logic [GEN_W-1:0]    best_gen;
  logic [SLOT_W-1:0]   best_slot;

  logic                out_free;
  logic                in_range;
  logic                smaller_handle;
  logic                take;
  logic                have_best_next;
  logic [DIST_W-1:0]   best_dist_next;
  logic [IDX_W-1:0]    best_index_next;
  logic [GEN_W-1:0]    best_gen_next;
  logic [SLOT_W-1:0]   best_slot_next;

  // Squared radius, refreshed every cycle from the register.
  assign r2_full = acquire_radius * acquire_radius;

  always_ff @(posedge clk) begin
    r2 <= DIST_W'(r2_full);
  end

  // A last entry waits until the result register is free.
  assign out_free = !out_valid || out_ready;
  assign q_pop    = !q_status.empty && (!q_rdata.last || out_free);

  // Running minimum; equal distances go to the smaller handle.
  always_comb begin
    in_range       = q_rdata.hit && (q_rdata.dist_sq <= r2);
    smaller_handle = (q_rdata.index != best_index) ? (q_rdata.index < best_index)
                                                   : (q_rdata.gen < best_gen);
    take = in_range && (!have_best || (q_rdata.dist_sq < best_dist)
                        || ((q_rdata.dist_sq == best_dist) && smaller_handle));
    have_best_next  = have_best || take;
    best_dist_next  = take ? q_rdata.dist_sq : best_dist;
    best_index_next = take ? q_rdata.index   : best_index;
    best_gen_next   = take ? q_rdata.gen     : best_gen;
    best_slot_next  = take ? q_rdata.slot    : best_slot;
  end

  // Search state; a last entry clears it for the next list.
  always_ff @(posedge clk) begin
    if (rst) begin
      have_best <= 1'b0;
    end else if (q_pop) begin
      have_best <= q_rdata.last ? 1'b0 : have_best_next;
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      best_dist  <= best_dist_next;
      best_index <= best_index_next;
      best_gen   <= best_gen_next;
      best_slot  <= best_slot_next;
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (q_pop && q_rdata.last) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop && q_rdata.last) begin
      out_found <= have_best_next;
      out_index <= have_best_next ? best_index_next : '0;
      out_gen   <= have_best_next ? best_gen_next   : '0;
      out_slot  <= have_best_next ? best_slot_next  : '0;
      out_dist  <= have_best_next ? best_dist_next  : '0;
    end
  end

endmodule

// ===== design/nearest_target_select_core.sv =====
// ----------------------------------------------------------------------------
// nearest_target_select_core
// Nearest eligible candidate search over a streamed candidate list.
// ----------------------------------------------------------------------------
// Candidates arrive as beats on s_axis, one per cycle while s_axis_tready is
// high; s_axis_tlast marks the last candidate of a list. A candidate is
// skipped when unusable, when it is the searcher itself or on the searcher's
// team, or when its squared distance exceeds the squared radius. After the
// last beat of a list one result beat leaves on m_axis: found in tuser, the
// winner's handle, list slot and squared distance in tdata (all zero when
// nothing was found). Lists without a last beat produce nothing.
// The last input beat passes three front stages (differences, squares, sum),
// then the queue and the result register. The back end takes one beat per
// cycle, its running minimum compare being combinational, unless a last entry
// waits on a stalled result. A four-entry queue decouples front from back, so
// input is still taken while a result waits; s_axis_tready drops only when
// the queue fills behind a stalled result.
// Reset clears the searcher registers to zero, empties the pipeline and the
// queue and drops any pending result. Configuration writes take effect at
// once; the user must make them only while no list is in progress (unchecked).
// ----------------------------------------------------------------------------
`include "nearest_target_select_core_macros.svh"

module nearest_target_select_core #(
  parameter int MAX_CANDIDATES = 1024
) (
  input  logic                                 clk,
  input  logic                                 rst,
  // Configuration write port.
  input  logic                                 cfg_we,
  input  logic [ntsel_pkg::CFG_ADDR_W-1:0]     cfg_addr,
  input  logic [ntsel_pkg::CFG_DATA_W-1:0]     cfg_wdata,
  // Candidate stream.
  input  logic                                 s_axis_tvalid,
  output logic                                 s_axis_tready,
  // cand_x[23:0], cand_y[47:24], cand_z[71:48], cand_team[79:72],
  // cand_index[99:80], cand_generation[111:100]
  input  logic [ntsel_pkg::IN_TDATA_W-1:0]     s_axis_tdata,
  // cand_usable[0]
  input  logic                                 s_axis_tuser,
  input  logic                                 s_axis_tlast,
  // Result stream.
  output logic                                 m_axis_tvalid,
  input  logic                                 m_axis_tready,
  // target_index[19:0], target_generation[31:20], target_slot[41:32],
  // target_dist_sq[91:42], zero[95:92]
  output logic [ntsel_pkg::OUT_TDATA_W-1:0]    m_axis_tdata,
  // found[0]
  output logic                                 m_axis_tuser
);
  import ntsel_pkg::*;

  localparam int SLOT_TOP = (MAX_CANDIDATES - 1 > SLOT_FIELD_MAX) ? SLOT_FIELD_MAX
                                                                  : MAX_CANDIDATES - 1;

  cfg_t          cfg;
  q_status_t     q_status;
  q_entry_t      q_wdata;
  q_entry_t      q_rdata;
  logic          q_push;
  logic          q_pop;

  logic [IDX_W-1:0]   res_index;
  logic [GEN_W-1:0]   res_gen;
  logic [SLOT_W-1:0]  res_slot;
  logic [DIST_W-1:0]  res_dist;

  // Searcher registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= '0;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        REG_SELF_X:     cfg.self_x          <= cfg_wdata[COORD_BITS-1:0];
        REG_SELF_Y:     cfg.self_y          <= cfg_wdata[COORD_BITS-1:0];
        REG_SELF_Z:     cfg.self_z          <= cfg_wdata[COORD_BITS-1:0];
        REG_RADIUS:     cfg.acquire_radius  <= cfg_wdata[RAD_W-1:0];
        REG_SELF_TEAM:  cfg.self_team       <= cfg_wdata[TEAM_W-1:0];
        REG_SELF_INDEX: cfg.self_index      <= cfg_wdata[IDX_W-1:0];
        REG_SELF_GEN:   cfg.self_generation <= cfg_wdata[GEN_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // Front end: classification and distance pipeline.
  ntsel_front #(
    .SLOT_TOP (SLOT_TOP)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .in_valid  (s_axis_tvalid),
    .in_ready  (s_axis_tready),
    .in_x      (s_axis_tdata[23:0]),
    .in_y      (s_axis_tdata[47:24]),
    .in_z      (s_axis_tdata[71:48]),
    .in_team   (s_axis_tdata[79:72]),
    .in_index  (s_axis_tdata[99:80]),
    .in_gen    (s_axis_tdata[111:100]),
    .in_usable (s_axis_tuser),
    .in_last   (s_axis_tlast),
    .q_status  (q_status),
    .q_push    (q_push),
    .q_wdata   (q_wdata)
  );

  // Queue between front and back.
  ntsel_fifo u_fifo (
    .clk    (clk),
    .rst    (rst),
    .push   (q_push),
    .wdata  (q_wdata),
    .pop    (q_pop),
    .rdata  (q_rdata),
    .status (q_status)
  );

  // Back end: running minimum and result register.
  ntsel_back u_back (
    .clk            (clk),
    .rst            (rst),
    .acquire_radius (cfg.acquire_radius),
    .q_status       (q_status),
    .q_rdata        (q_rdata),
    .q_pop          (q_pop),
    .out_valid      (m_axis_tvalid),
    .out_ready      (m_axis_tready),
    .out_found      (m_axis_tuser),
    .out_index      (res_index),
    .out_gen        (res_gen),
    .out_slot       (res_slot),
    .out_dist       (res_dist)
  );

  // Result beat packing.
  assign m_axis_tdata = {4'b0000, res_dist, res_slot, res_gen, res_index};

  // The front never pushes into a full queue.
  `NTS_ASSERT_IMP(a_queue_no_overflow, q_push, !q_status.full)
  // The back never pops an empty queue.
  `NTS_ASSERT_IMP(a_queue_no_underflow, q_pop, !q_status.empty)
  // A result without a winner carries all-zero fields.
  `NTS_ASSERT_IMP(a_empty_result_zero, m_axis_tvalid && !m_axis_tuser, m_axis_tdata == '0)
  // A last entry popped always leaves a result beat pending.
  `NTS_ASSERT_NXT(a_last_makes_result, q_pop && q_rdata.last, m_axis_tvalid)

endmodule

// ===== tb/sv/nearest_target_select_core_tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// nearest_target_select_core_tb
// Self-checking testbench for the nearest target select core. A directed
// table covers reset values, field extremes, every skip rule, the radius edge
// and handle tie-breaks. Random candidate lists then run under several
// searcher settings, including one list long enough to saturate the slot
// number. Sender idling and receiver stalls vary by phase, and one long
// receiver hold-off backs the core up. Every result beat is checked field by
// field against its table row or an in-bench model of the running minimum search.
// ----------------------------------------------------------------------------
module nearest_target_select_core_tb;
  import ntsel_pkg::*;

  localparam int RUN_LIMIT   = 400000;
  localparam int HOLD_CYCLES = 300;
  localparam int SETTLE_GAP  = 8;
  localparam int LONG_LIST   = 1030;
  // Register index outside the map; writes there must be ignored.
  localparam logic [CFG_ADDR_W-1:0] REG_UNMAPPED = 3'd7;

  // One candidate as presented on the input stream.
  typedef struct packed {
    logic [COORD_BITS-1:0] x;
    logic [COORD_BITS-1:0] y;
    logic [COORD_BITS-1:0] z;
    logic [TEAM_W-1:0]     team;
    logic [IDX_W-1:0]      index;
    logic [GEN_W-1:0]      gen;
    logic                  usable;
    logic                  last;
  } cand_t;

  // One search result as carried by the output stream.
  typedef struct packed {
    logic              found;
    logic [IDX_W-1:0]  index;
    logic [GEN_W-1:0]  gen;
    logic [SLOT_W-1:0] slot;
    logic [DIST_W-1:0] dist_sq;
  } target_t;

  // One row of the directed table: a register write or a candidate beat.
  typedef struct {
    bit                    is_write;
    logic [CFG_ADDR_W-1:0] addr;
    logic [CFG_DATA_W-1:0] data;
    cand_t                 cand;
    bit                    typed;
    target_t               want;
  } stim_row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic                   cfg_we        = 1'b0;
  logic [CFG_ADDR_W-1:0]  cfg_addr      = '0;
  logic [CFG_DATA_W-1:0]  cfg_wdata     = '0;
  logic                   s_axis_tvalid = 1'b0;
  logic                   s_axis_tready;
  logic [IN_TDATA_W-1:0]  s_axis_tdata  = '0;
  logic                   s_axis_tuser  = 1'b0;
  logic                   s_axis_tlast  = 1'b0;
  logic                   m_axis_tvalid;
  logic                   m_axis_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] m_axis_tdata;
  logic                   m_axis_tuser;

  nearest_target_select_core dut (
    .clk          (clk),
    .rst          (rst),
    .cfg_we       (cfg_we),
    .cfg_addr     (cfg_addr),
    .cfg_wdata    (cfg_wdata),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .s_axis_tlast (s_axis_tlast),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Searcher settings and running search state of the in-bench model.
  cfg_t              search_cfg = '0;
  bit                has_best   = 1'b0;
  logic [DIST_W-1:0] best_dist  = '0;
  logic [IDX_W-1:0]  best_index = '0;
  logic [GEN_W-1:0]  best_gen   = '0;
  logic [SLOT_W-1:0] best_slot  = '0;
  logic [SLOT_W-1:0] slot_count = '0;

  target_t   pending_targets[$];
  stim_row_t stim_table[$];
  int        mismatch_count = 0;
  int        cycle_count    = 0;

  // Traffic shaping, set per phase by the main sequence.
  int idle_pct   = 0;
  int stall_pct  = 0;
  bit burst      = 1'b0;
  int hold_req   = 0;
  int hold_seen  = 0;
  int hold_left  = 0;

  // Squared difference along one axis of two signed Q20.4 coordinates.
  function automatic logic [DIST_W-1:0] axis_square(input logic [COORD_BITS-1:0] a,
                                                    input logic [COORD_BITS-1:0] b);
    logic signed [COORD_BITS:0] diff;
    logic [COORD_BITS:0]        mag;
    diff = $signed({a[COORD_BITS-1], a}) - $signed({b[COORD_BITS-1], b});
    mag  = (diff < 0) ? -diff : diff;
    return DIST_W'(mag) * DIST_W'(mag);
  endfunction

  // Folds one accepted candidate into the running minimum. Returns 1 with the
  // result when the candidate closes a list.
  function automatic bit nearest_update(input cand_t c, output target_t t);
    logic [DIST_W-1:0] d;
    logic [DIST_W-1:0] r2;
    bit                smaller_handle;
    t = '0;
    if (c.usable && !(c.index == search_cfg.self_index &&
                      c.gen == search_cfg.self_generation) &&
        c.team != search_cfg.self_team) begin
      d = axis_square(c.x, search_cfg.self_x) + axis_square(c.y, search_cfg.self_y) +
          axis_square(c.z, search_cfg.self_z);
      r2 = DIST_W'(search_cfg.acquire_radius) * DIST_W'(search_cfg.acquire_radius);
      smaller_handle = (c.index != best_index) ? (c.index < best_index) : (c.gen < best_gen);
      if (d <= r2 && (!has_best || d < best_dist || (d == best_dist && smaller_handle))) begin
        has_best   = 1'b1;
        best_dist  = d;
        best_index = c.index;
        best_gen   = c.gen;
        best_slot  = slot_count;
      end
    end
    // The slot number sticks at the top of its range on long lists.
    if (slot_count < SLOT_FIELD_MAX)
      slot_count++;
    if (!c.last)
      return 1'b0;
    if (has_best)
      t = '{found: 1'b1, index: best_index, gen: best_gen, slot: best_slot,
            dist_sq: best_dist};
    has_best   = 1'b0;
    best_dist  = '0;
    best_index = '0;
    best_gen   = '0;
    best_slot  = '0;
    slot_count = '0;
    return 1'b1;
  endfunction

  // Random coordinate offset in the range -reach .. reach.
  function automatic logic [COORD_BITS-1:0] jitter(input longint reach);
    int unsigned span;
    span = 32'(2 * reach);
    return COORD_BITS'(longint'($urandom_range(0, span)) - reach);
  endfunction

  // Random candidate, mostly placed around the searcher so hits are common.
  function automatic cand_t random_cand(input bit last);
    cand_t       c;
    longint      reach;
    int unsigned pick;
    reach = longint'(search_cfg.acquire_radius) * 3 / 4 + 2;
    pick  = $urandom_range(9);
    c.x = search_cfg.self_x;
    c.y = search_cfg.self_y;
    c.z = search_cfg.self_z;
    if (pick == 0) begin
      c.x = COORD_BITS'($urandom);
      c.y = COORD_BITS'($urandom);
      c.z = COORD_BITS'($urandom);
    end else if (pick > 2) begin
      c.x = c.x + jitter(reach);
      c.y = c.y + jitter(reach);
      c.z = c.z + jitter(reach);
    end
    c.team = ($urandom_range(5) == 0) ? search_cfg.self_team : TEAM_W'($urandom);
    case ($urandom_range(2))
      0:       c.index = IDX_W'($urandom_range(0, 7));
      1:       c.index = search_cfg.self_index;
      default: c.index = IDX_W'($urandom);
    endcase
    case ($urandom_range(2))
      0:       c.gen = GEN_W'($urandom_range(0, 3));
      1:       c.gen = search_cfg.self_generation;
      default: c.gen = GEN_W'($urandom);
    endcase
    c.usable = ($urandom_range(7) != 0);
    c.last   = last;
    return c;
  endfunction

  function automatic void check_field(input string name, input logic [DIST_W-1:0] want,
                                      input logic [DIST_W-1:0] got);
    if (want !== got) begin
      $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
      mismatch_count++;
    end
  endfunction

  // Directed table builders.
  function automatic void row_cand(input logic [COORD_BITS-1:0] x, input logic [COORD_BITS-1:0] y,
                                   input logic [COORD_BITS-1:0] z, input logic [TEAM_W-1:0] team,
                                   input logic [IDX_W-1:0] index, input logic [GEN_W-1:0] gen,
                                   input bit usable, input bit last);
    stim_row_t r;
    r          = '{default: '0};
    r.cand     = '{x: x, y: y, z: z, team: team, index: index, gen: gen,
                   usable: usable, last: last};
    stim_table.push_back(r);
  endfunction

  function automatic void row_want(input bit found, input logic [IDX_W-1:0] index,
                                   input logic [GEN_W-1:0] gen, input logic [SLOT_W-1:0] slot,
                                   input logic [DIST_W-1:0] dist_sq);
    stim_table[stim_table.size() - 1].typed = 1'b1;
    stim_table[stim_table.size() - 1].want  =
      '{found: found, index: index, gen: gen, slot: slot, dist_sq: dist_sq};
  endfunction

  function automatic void row_write(input logic [CFG_ADDR_W-1:0] addr,
                                    input logic [CFG_DATA_W-1:0] data);
    stim_row_t r;
    r          = '{default: '0};
    r.is_write = 1'b1;
    r.addr     = addr;
    r.data     = data;
    stim_table.push_back(r);
  endfunction

  // One register write; the model copy follows the core's register map.
  task automatic write_reg(input logic [CFG_ADDR_W-1:0] addr, input logic [CFG_DATA_W-1:0] data);
    cfg_we    <= 1'b1;
    cfg_addr  <= addr;
    cfg_wdata <= data;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (addr)
      REG_SELF_X:     search_cfg.self_x          = data[COORD_BITS-1:0];
      REG_SELF_Y:     search_cfg.self_y          = data[COORD_BITS-1:0];
      REG_SELF_Z:     search_cfg.self_z          = data[COORD_BITS-1:0];
      REG_RADIUS:     search_cfg.acquire_radius  = data[RAD_W-1:0];
      REG_SELF_TEAM:  search_cfg.self_team       = data[TEAM_W-1:0];
      REG_SELF_INDEX: search_cfg.self_index      = data[IDX_W-1:0];
      REG_SELF_GEN:   search_cfg.self_generation = data[GEN_W-1:0];
      default: ;
    endcase
    @(posedge clk);
  endtask

  task automatic apply_settings(input cfg_t s);
    write_reg(REG_SELF_X, s.self_x);
    write_reg(REG_SELF_Y, s.self_y);
    write_reg(REG_SELF_Z, s.self_z);
    write_reg(REG_RADIUS, CFG_DATA_W'(s.acquire_radius));
    write_reg(REG_SELF_TEAM, CFG_DATA_W'(s.self_team));
    write_reg(REG_SELF_INDEX, CFG_DATA_W'(s.self_index));
    write_reg(REG_SELF_GEN, CFG_DATA_W'(s.self_generation));
  endtask

  // Offers one candidate beat and waits for it to be taken. The expected
  // result, if the beat closes a list, is either given or predicted.
  task automatic offer_cand(input cand_t c, input bit typed, input target_t want);
    target_t t;
    if (!burst)
      while ($urandom_range(99) < idle_pct) begin
        s_axis_tvalid <= 1'b0;
        @(posedge clk);
      end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {c.gen, c.index, c.team, c.z, c.y, c.x};
    s_axis_tuser  <= c.usable;
    s_axis_tlast  <= c.last;
    do @(posedge clk); while (!s_axis_tready);
    if (nearest_update(c, t))
      pending_targets.push_back(typed ? want : t);
  endtask

  // Lets all expected results drain, then lets the pipeline run empty.
  task automatic settle();
    s_axis_tvalid <= 1'b0;
    while (pending_targets.size() != 0)
      @(posedge clk);
    repeat (SETTLE_GAP) @(posedge clk);
  endtask

  function automatic cfg_t phase_settings(input int p);
    cfg_t s;
    s.self_x          = COORD_BITS'($urandom);
    s.self_y          = COORD_BITS'($urandom);
    s.self_z          = COORD_BITS'($urandom);
    s.acquire_radius  = RAD_W'($urandom & ((1 << $urandom_range(1, RAD_W)) - 1));
    s.self_team       = TEAM_W'($urandom);
    s.self_index      = IDX_W'($urandom);
    s.self_generation = GEN_W'($urandom);
    case (p)
      0: begin
        s.self_x = '0;
        s.self_y = '0;
        s.self_z = '0;
        s.acquire_radius = 2000;
      end
      1: s = '{self_x: 24'h800000, self_y: 24'h800000, self_z: 24'h800000,
               acquire_radius: '1, self_team: '0, self_index: '0, self_generation: '0};
      2: s = '{self_x: 24'h7FFFFF, self_y: 24'h7FFFFF, self_z: 24'h7FFFFF,
               acquire_radius: '1, self_team: '1, self_index: '1, self_generation: '1};
      3: s.acquire_radius = '0;
      default: ;
    endcase
    return s;
  endfunction

  // Receiver: random stalls, plus a long hold-off on request.
  always @(posedge clk) begin
    if (rst) begin
      m_axis_tready <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left--;
      m_axis_tready <= 1'b0;
    end else if (hold_seen != hold_req) begin
      hold_seen = hold_req;
      hold_left = HOLD_CYCLES;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= ($urandom_range(99) >= stall_pct);
    end
  end

  // Result checker: each accepted result beat against the oldest expectation.
  always @(posedge clk) begin : result_check
    target_t want;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      if (pending_targets.size() == 0) begin
        $error("result beat with no result expected");
        mismatch_count++;
      end else begin
        want = pending_targets.pop_front();
        check_field("found", DIST_W'(want.found), DIST_W'(m_axis_tuser));
        check_field("target_index", DIST_W'(want.index), DIST_W'(m_axis_tdata[19:0]));
        check_field("target_generation", DIST_W'(want.gen), DIST_W'(m_axis_tdata[31:20]));
        check_field("target_slot", DIST_W'(want.slot), DIST_W'(m_axis_tdata[41:32]));
        check_field("target_dist_sq", want.dist_sq, m_axis_tdata[91:42]);
      end
    end
  end

  // Watchdog.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > RUN_LIMIT) begin
      $display("nearest_target_select_core test failed");
      $finish;
    end
  end

  initial begin
    int    sent;
    int    len;
    int    quota;
    cand_t c;

    // Directed rows at reset settings: searcher at the origin, radius zero.
    row_cand('0, '0, '0, 1, 5, 1, 1, 1);
    row_want(1, 5, 1, 0, 0);
    row_cand('0, '0, '0, 0, 6, 0, 1, 1);          // own team
    row_want(0, 0, 0, 0, 0);
    row_cand(24'h000010, '0, '0, 1, 6, 0, 1, 1);  // just off a zero radius
    row_want(0, 0, 0, 0, 0);
    row_cand('0, '0, '0, 1, 6, 0, 0, 1);          // not usable
    row_want(0, 0, 0, 0, 0);
    row_cand('0, '0, '0, 1, 0, 0, 1, 1);          // the searcher itself
    row_want(0, 0, 0, 0, 0);

    // Searcher at the x minimum and y maximum of the coordinate range, largest radius.
    row_write(REG_SELF_X, 24'h800000);
    row_write(REG_SELF_Y, 24'h7FFFFF);
    row_write(REG_SELF_Z, 24'h000000);
    row_write(REG_RADIUS, 24'h7FFFFF);
    row_write(REG_SELF_TEAM, 24'h0000FF);
    row_write(REG_SELF_INDEX, 24'h0FFFFF);
    row_write(REG_SELF_GEN, 24'h000FFF);
    row_write(REG_UNMAPPED, 24'hFFFFFF);

    // Ties at zero distance: smaller index wins, then smaller generation.
    row_cand(24'h800000, 24'h7FFFFF, '0, 0, 20'hFFFFF, 12'hFFE, 1, 0);
    row_cand(24'h800000, 24'h7FFFFF, '0, 0, 20'hFFFFE, 12'hFFF, 1, 0);
    row_cand(24'h800000, 24'h7FFFFF, '0, 0, 20'hFFFFE, 12'h000, 1, 1);
    // Opposite corner, far outside.
    row_cand(24'h7FFFFF, 24'h800000, 24'h7FFFFF, 0, 1, 1, 1, 1);
    row_want(0, 0, 0, 0, 0);
    // Exactly on the radius, then one step beyond it.
    row_cand(24'hFFFFFF, 24'h7FFFFF, '0, 1, 2, 2, 1, 1);
    row_cand(24'h000000, 24'h7FFFFF, '0, 1, 2, 2, 1, 1);
    row_want(0, 0, 0, 0, 0);
    row_cand(24'h800000, 24'h7FFFFF, '0, 1, 20'hFFFFF, 12'hFFF, 1, 1);
    row_want(0, 0, 0, 0, 0);
    row_cand(24'h800000, 24'h7FFFFF, '0, 8'hFF, 3, 3, 1, 1);
    row_want(0, 0, 0, 0, 0);
    // Nearer candidate replaces; a farther one with a smaller handle does not.
    row_cand(24'h8000A0, 24'h7FFFFF, '0, 1, 9, 9, 1, 0);
    row_cand(24'h800010, 24'h7FFFEF, '0, 1, 20, 1, 1, 0);
    row_cand(24'h800000, 24'h7FFFFF, 24'hFFFFC0, 1, 4, 0, 1, 0);
    row_cand(24'h800030, 24'h7FFFFF, '0, 1, 30, 0, 0, 1);

    repeat (2) @(posedge clk);
    rst <= 1'b0;

    foreach (stim_table[i]) begin
      if (stim_table[i].is_write) begin
        settle();
        write_reg(stim_table[i].addr, stim_table[i].data);
      end else begin
        offer_cand(stim_table[i].cand, stim_table[i].typed, stim_table[i].want);
      end
    end
    settle();

    // Random lists under a range of searcher settings and traffic patterns.
    for (int p = 0; p < 8; p++) begin
      apply_settings(phase_settings(p));
      idle_pct  = (p % 4 == 1) ? 65 : (p % 4 == 3) ? 19 : 0;
      stall_pct = (p % 4 == 2) ? 65 : (p % 4 == 3) ? 19 : 0;
      // Long receiver hold-off while lists keep coming.
      if (p == 0)
        hold_req++;
      quota = (p == 0) ? 32 : 10;
      sent  = 0;
      while (sent < quota) begin
        len   = ($urandom_range(9) == 0) ? $urandom_range(13, 40) : $urandom_range(1, 8);
        burst = ($urandom_range(3) == 0);
        for (int k = 0; k < len; k++) begin
          offer_cand(random_cand(k == len - 1), 1'b0, '0);
          sent++;
        end
      end
      settle();
    end

    // One list past the slot range; the nearest candidates come at its end.
    apply_settings('{self_x: '0, self_y: '0, self_z: '0, acquire_radius: 4096,
                     self_team: 3, self_index: 77, self_generation: 5});
    idle_pct  = 19;
    stall_pct = 19;
    burst     = 1'b0;
    for (int k = 0; k < LONG_LIST; k++) begin
      c = random_cand(k == LONG_LIST - 1);
      if (k < LONG_LIST - 6) begin
        c.index = IDX_W'($urandom_range(16, (1 << IDX_W) - 1));
      end else begin
        c.x      = '0;
        c.y      = '0;
        c.z      = '0;
        c.team   = 4;
        c.index  = IDX_W'($urandom_range(0, 3));
        c.usable = 1'b1;
      end
      offer_cand(c, 1'b0, '0);
    end
    settle();

    if (mismatch_count == 0)
      $display("nearest_target_select_core test passed");
    else
      $display("nearest_target_select_core test failed");
    $finish;
  end

endmodule

// ===== filelist.f =====
+incdir+design
design/ntsel_pkg.sv
design/ntsel_front.sv
design/ntsel_fifo.sv
design/ntsel_back.sv
design/nearest_target_select_core.sv
tb/sv/nearest_target_select_core_tb.sv
